>>> rtl/vlrr_pkg.sv
package vlrr_pkg;

  localparam logic [1:0] ST_ADDED   = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_CHOSEN  = 2'd2;
  localparam logic [1:0] ST_NOMATCH = 2'd3;

  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_TRIG = 1'b1;

  localparam int IN_BITS  = 124;
  localparam int OUT_BITS = 56;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input word
    logic add;       // write layer, count up
    logic scan_clr;  // clear scan registers
    logic scan1;     // first walk step
    logic scan2;     // second walk step
    logic modstep;   // one restoring step of counter mod count
    logic grp_upd;   // write group counter
    logic mul;       // start multiply step
    logic clampit;   // compute clamps
  } vlrr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_trig;
    logic full;
    logic scan_last;
    logic found;
    logic hit_pick;
    logic zero_len;
  } vlrr_stat_t;

endpackage

>>> rtl/vlrr_datapath.sv
module vlrr_datapath #(
  parameter int MAX_LAYERS  = 16,
  parameter int NUM_GROUPS  = 16,
  parameter int LENGTH_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  vlrr_pkg::vlrr_cmd_t           cmd,
  output vlrr_pkg::vlrr_stat_t          stat,
  input  logic [vlrr_pkg::IN_BITS-1:0]  in_word,
  output logic [1:0]                    res_status,
  output logic [5:0]                    res_index,
  output logic [23:0]                   res_start,
  output logic [23:0]                   res_length
);
  import vlrr_pkg::*;

  localparam int IW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int CW = $clog2(MAX_LAYERS + 1);
  localparam int GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  // the length field is 24 bits wide, so wider settings keep all of it
  localparam int LB = (LENGTH_BITS < 24) ? LENGTH_BITS : 24;
  localparam int PW = 18 + LB;
  // reciprocal of the group count and the residue of -128
  localparam int GRM  = (65536 + NUM_GROUPS - 1) / NUM_GROUPS;
  localparam int GOFF = (NUM_GROUPS - (128 % NUM_GROUPS)) % NUM_GROUPS;

  logic [6:0]    lo_mem  [MAX_LAYERS];
  logic [6:0]    hi_mem  [MAX_LAYERS];
  logic [7:0]    grp_mem [MAX_LAYERS];
  logic [16:0]   st_mem  [MAX_LAYERS];
  logic [16:0]   en_mem  [MAX_LAYERS];
  logic [LB-1:0] len_mem [MAX_LAYERS];
  logic [6:0]    gcnt    [NUM_GROUPS];

  logic [IN_BITS-1:0] held;
  logic [CW-1:0] layer_count;
  logic          func;
  logic [6:0]    vel;
  logic [17:0]   so, eo;
  logic [CW-1:0] idx;
  logic [CW-1:0] mcount;
  logic [IW-1:0] first;
  logic          found;
  logic [IW-1:0] chosen;
  logic [6:0]    rem;
  logic [2:0]    mstep;
  logic [GW-1:0] gsel;
  logic [CW-1:0] seen;
  logic [PW-1:0] prod_s, prod_e;
  logic [LB-1:0] n;
  logic [17:0]   sf_sel, ef_sel;

  assign func = held[0];
  assign vel  = held[7:1];
  assign so   = held[105:88];
  assign eo   = held[123:106];

  logic [IW-1:0] ia;
  logic          hit;
  assign ia  = idx[IW-1:0];
  assign hit = (idx < layer_count) && (vel >= lo_mem[ia]) && (vel <= hi_mem[ia]);

  // mathematical residue of the group: (g + 128) mod count by reciprocal,
  // then shifted back by the residue of -128
  logic [GW-1:0] gred;
  logic [7:0]    gu;
  logic [24:0]   gq;
  logic [14:0]   gqn;
  logic [14:0]   gdiff;
  logic [7:0]    gsum;
  logic [7:0]    gfin;
  always_comb begin
    gu    = grp_mem[first] ^ 8'h80;
    gq    = 25'(gu) * 25'(GRM);
    gqn   = 15'(gq[23:16]) * 15'(NUM_GROUPS);
    gdiff = 15'(gu) - gqn;
    gsum  = gdiff[7:0] + 8'(GOFF);
    gfin  = (gsum >= 8'(NUM_GROUPS)) ? gsum - 8'(NUM_GROUPS) : gsum;
    gred  = GW'(gfin);
  end

  // restoring mod step: rem - count<<k
  logic [13:0] sub_v;
  assign sub_v = 14'(mcount) << mstep;

  assign stat.is_trig   = func;
  assign stat.full      = (layer_count >= CW'(MAX_LAYERS));
  assign stat.scan_last = (idx >= CW'(MAX_LAYERS - 1)) || (idx + 1'b1 >= layer_count);
  assign stat.found     = found;
  assign stat.hit_pick  = hit && (seen == CW'(rem));
  assign stat.zero_len  = (n == '0);

  assign sf_sel = so[17] ? 18'(st_mem[chosen]) : so;
  assign ef_sel = eo[17] ? 18'(en_mem[chosen]) : eo;

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_count <= '0;
      for (int g = 0; g < NUM_GROUPS; g++) gcnt[g] <= '0;
    end else begin
      if (cmd.add && !stat.full) layer_count <= layer_count + 1'b1;
      if (cmd.grp_upd) gcnt[gsel] <= rem + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) held <= in_word;
    if (cmd.add && !stat.full) begin
      lo_mem[layer_count[IW-1:0]]  <= held[14:8];
      hi_mem[layer_count[IW-1:0]]  <= held[21:15];
      grp_mem[layer_count[IW-1:0]] <= held[29:22];
      st_mem[layer_count[IW-1:0]]  <= held[46:30];
      en_mem[layer_count[IW-1:0]]  <= held[63:47];
      len_mem[layer_count[IW-1:0]] <= held[64 +: LB];
    end
    if (cmd.scan_clr) begin
      idx <= '0; mcount <= '0; found <= 1'b0; first <= '0; seen <= '0; mstep <= 3'd7;
    end
    if (cmd.scan1) begin
      if (hit) begin
        mcount <= mcount + 1'b1;
        if (!found) begin first <= ia; found <= 1'b1; end
      end
      idx <= idx + 1'b1;
    end
    if (cmd.modstep) begin
      if (mstep == 3'd7) begin
        gsel <= gred;
        rem  <= gcnt[gred];
        mstep <= 3'd6;
        idx <= CW'(first);
      end else begin
        if ({7'd0, rem} >= sub_v) rem <= rem - sub_v[6:0];
        mstep <= mstep - 3'd1;
      end
    end
    if (cmd.scan2) begin
      if (stat.hit_pick) begin
        chosen <= ia;
        n <= len_mem[ia];
      end
      if (hit) seen <= seen + 1'b1;
      idx <= idx + 1'b1;
    end
    if (cmd.mul) begin
      prod_s <= PW'(sf_sel) * PW'(n);
      prod_e <= PW'(ef_sel) * PW'(n);
    end
  end

  logic [PW-17:0] s_raw, e_raw;
  logic [PW-16:0] s_cl, e_cl;
  always_comb begin
    s_raw = prod_s[PW-1:16];
    e_raw = prod_e[PW-1:16];
    s_cl = (s_raw > (PW-16)'(n - 1'b1)) ? (PW-15)'(n - 1'b1) : (PW-15)'(s_raw);
    e_cl = (e_raw > (PW-16)'(n)) ? (PW-15)'(n) : (PW-15)'(e_raw);
    if (e_cl < s_cl + 1'b1) e_cl = s_cl + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.add) begin
      res_status <= stat.full ? ST_FULL : ST_ADDED;
      res_index  <= stat.full ? 6'd0 : 6'(layer_count);
      res_start  <= '0;
      res_length <= '0;
    end else if (cmd.scan2 && !found) begin
      res_status <= ST_NOMATCH;
      res_index <= '0; res_start <= '0; res_length <= '0;
    end else if (cmd.clampit) begin
      res_status <= ST_CHOSEN;
      res_index  <= 6'(chosen);
      res_start  <= stat.zero_len ? 24'd0 : 24'(s_cl);
      res_length <= stat.zero_len ? 24'd0 : 24'(e_cl - s_cl);
    end
  end
endmodule

>>> rtl/vlrr_ctrl.sv
module vlrr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_fire,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  vlrr_pkg::vlrr_stat_t stat,
  output vlrr_pkg::vlrr_cmd_t  cmd
);
  import vlrr_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DEC, S_SCAN1, S_MOD, S_SCAN2, S_MUL, S_CLAMP, S_OUT}
    state_t;
  state_t state;
  logic [2:0] mcnt;

  assign in_ready = (state == S_IDLE) || (state == S_OUT && out_ready);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd = '0;
    cmd.load = in_fire;
    unique case (state)
      S_DEC: begin
        cmd.add = !stat.is_trig;
        cmd.scan_clr = stat.is_trig;
      end
      S_SCAN1: cmd.scan1 = 1'b1;
      S_MOD:   cmd.modstep = 1'b1;
      S_SCAN2: begin
        cmd.scan2 = 1'b1;
        cmd.grp_upd = stat.found && (mcnt == 3'd0);
      end
      S_MUL:   cmd.mul = 1'b1;
      S_CLAMP: cmd.clampit = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mcnt <= '0;
    end else begin
      unique case (state)
        S_IDLE:  if (in_fire) state <= S_DEC;
        S_DEC:   state <= stat.is_trig ? S_SCAN1 : S_OUT;
        S_SCAN1: if (stat.scan_last) begin state <= S_MOD; mcnt <= 3'd7; end
        S_MOD: begin
          if (!stat.found) begin state <= S_SCAN2; mcnt <= '0; end
          else if (mcnt == 3'd0) state <= S_SCAN2;
          else mcnt <= mcnt - 3'd1;
        end
        S_SCAN2: begin
          mcnt <= 3'd1;
          if (!stat.found) state <= S_OUT;
          else if (stat.hit_pick) state <= S_MUL;
        end
        S_MUL:   state <= S_CLAMP;
        S_CLAMP: state <= S_OUT;
        S_OUT:   if (out_ready) state <= in_fire ? S_DEC : S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> rtl/velocity_layer_round_robin_pick_top.sv
// velocity layer round-robin sample picker
// s_axis carries one word per item: add a layer (func 0) or trigger (func 1)
// m_axis returns exactly one word per item: status, layer index, slice
// an add passes from decode straight to its result
// a trigger walks the table to count matches, then takes a load step and a
// 7 step restoring mod of the group counter, a second walk to the picked
// match, a multiply step and a clamp step
// one item at a time; the next word is taken when the result is taken
// reset clears the layer count and all group counters; table entries are
// written by add words only, so no clearing pass is needed
// when the receiver stalls the result holds on m_axis and s_axis_tready stays low
module velocity_layer_round_robin_pick_top #(
  parameter int MAX_LAYERS  = 16,
  parameter int NUM_GROUPS  = 16,
  parameter int LENGTH_BITS = 24
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // velocity, vel_min, vel_max, rr_group, start_frac, end_frac, length_samples,
  // start_override, end_override, zero fill
  input  logic [127:0] s_axis_tdata,
  input  logic         s_axis_tuser,   // func
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, layer_index, slice_start, slice_length
  output logic [vlrr_pkg::OUT_BITS-1:0] m_axis_tdata
);
  import vlrr_pkg::*;

  vlrr_cmd_t  cmd;
  vlrr_stat_t stat;
  logic       in_fire;
  logic [1:0] r_st;
  logic [5:0] r_ix;
  logic [23:0] r_s, r_l;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  vlrr_ctrl u_ctrl (
    .clk, .rst, .in_fire, .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .stat, .cmd
  );

  // func in bit 0 of the internal word, tdata above it
  vlrr_datapath #(.MAX_LAYERS(MAX_LAYERS), .NUM_GROUPS(NUM_GROUPS),
                  .LENGTH_BITS(LENGTH_BITS)) u_dp (
    .clk, .rst, .cmd, .stat,
    .in_word({s_axis_tdata[122:0], s_axis_tuser}),
    .res_status(r_st), .res_index(r_ix), .res_start(r_s), .res_length(r_l)
  );

  assign m_axis_tdata = {r_l, r_s, r_ix, r_st};
endmodule

>>> rtl/vlrr_checker.sv
module vlrr_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [55:0]  m_axis_tdata
);
  import vlrr_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");
  a_noaccept: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("accepted while result waits");
  a_nomatch: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1:0] != ST_CHOSEN |-> m_axis_tdata[55:32] == 24'd0)
    else $error("nonzero length without pick");
  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("valid after reset");
endmodule

bind velocity_layer_round_robin_pick_top vlrr_checker u_chk (
  .clk, .rst, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata
);
